@@ design/icov_pkg.sv @@
// ----------------------------------------------------------------------------
// icov_pkg
// Shared types, widths and constants of the interval coverage tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package icov_pkg;

  localparam int VAL_W      = 64;
  localparam int CNT_W      = 45;
  localparam int COV_W      = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int PROD_W     = CNT_W + COV_W;
  localparam int DIV_STEPS  = COV_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int REM_W      = CNT_W + 1;

  localparam logic [COV_W-1:0] PPM_SCALE = COV_W'(1000000);
  localparam logic [CNT_W-1:0] OBS_LIMIT = CNT_W'(64'd18446744073709);

  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b1;

  localparam logic KIND_OBSERVE   = 1'b0;
  localparam logic KIND_CLEAR     = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL,
    ST_DIV,
    ST_WB
  } fsm_state_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] num;
    logic [CNT_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [COV_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ design/icov_if.sv @@
// ----------------------------------------------------------------------------
// icov_if
// Valid/ready channels of the interval coverage tracker.
// ----------------------------------------------------------------------------
`default_nettype none

interface icov_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [icov_pkg::VAL_W-1:0]   interval_low;
  logic signed [icov_pkg::VAL_W-1:0]   interval_high;
  logic signed [icov_pkg::VAL_W-1:0]   realized;

  modport source (output valid, kind, interval_low, interval_high, realized, input ready);
  modport sink   (input valid, kind, interval_low, interval_high, realized, output ready);
endinterface

interface icov_out_if;
  logic                           valid;
  logic                           ready;
  logic                           status;
  logic [icov_pkg::CNT_W-1:0]     observation_count;
  logic [icov_pkg::CNT_W-1:0]     covered_count;
  logic [icov_pkg::COV_W-1:0]     coverage;
  logic                           within_band;

  modport source (output valid, status, observation_count, covered_count, coverage,
                  within_band, input ready);
  modport sink   (input valid, status, observation_count, covered_count, coverage,
                  within_band, output ready);
endinterface

interface icov_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [icov_pkg::CFG_IDX_W-1:0]    index;
  logic [icov_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/icov_div.sv @@
// ----------------------------------------------------------------------------
// icov_div
// Restoring divider, one quotient bit per cycle. Expects num < den * 2^COV_W.
// ----------------------------------------------------------------------------
`default_nettype none

module icov_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire icov_pkg::div_req_t req,
  output      icov_pkg::div_rsp_t rsp
);

  logic                              busy;
  logic [icov_pkg::STEP_W-1:0]       step;
  logic [icov_pkg::REM_W-1:0]        rem;
  logic [icov_pkg::COV_W-1:0]        low_bits;
  logic [icov_pkg::COV_W-1:0]        quot;
  logic [icov_pkg::CNT_W-1:0]        den;
  logic [icov_pkg::REM_W-1:0]        trial;
  logic [icov_pkg::REM_W-1:0]        diff;
  logic                              fits;

  always_comb begin
    trial = {rem[icov_pkg::CNT_W-1:0], low_bits[icov_pkg::COV_W-1]};
    diff  = trial - {1'b0, den};
    fits  = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == icov_pkg::STEP_W'(icov_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (req.start) begin
      // upper part of the dividend is already below the divisor
      rem      <= {1'b0, req.num[icov_pkg::PROD_W-1:icov_pkg::COV_W]};
      low_bits <= req.num[icov_pkg::COV_W-1:0];
      den      <= req.den;
      quot     <= '0;
    end else if (busy) begin
      rem      <= fits ? diff : trial;
      low_bits <= {low_bits[icov_pkg::COV_W-2:0], 1'b0};
      quot     <= {quot[icov_pkg::COV_W-2:0], fits};
    end
  end

  assign rsp.busy = busy;
  assign rsp.quot = quot;

endmodule

`default_nettype wire

@@ design/interval_coverage_tracker_top.sv @@
// ----------------------------------------------------------------------------
// interval_coverage_tracker_top
// Counts interval observations and hits, reports coverage in ppm and band check.
// ----------------------------------------------------------------------------
// an item that leaves a nonzero count passes through the states update, multiply,
//   divide and writeback; the bit-serial divider holds the fsm in divide until it is done
// a new item is taken only in idle, once the previous one has been written back
// items leaving the count at zero skip the divider and go from multiply to writeback
// synchronous reset clears both counters, both config registers and the fsm
`default_nettype none

module interval_coverage_tracker_top (
  input wire logic  clk,
  input wire logic  rst,
  icov_in_if.sink   item,
  icov_out_if.source result,
  icov_cfg_if.sink  cfg
);

  icov_pkg::fsm_state_t state, state_next;

  logic                                 kind_q;
  logic signed [icov_pkg::VAL_W-1:0]    low_q;
  logic signed [icov_pkg::VAL_W-1:0]    high_q;
  logic signed [icov_pkg::VAL_W-1:0]    real_q;
  logic [icov_pkg::CNT_W-1:0]           obs, obs_next;
  logic [icov_pkg::CNT_W-1:0]           hits, hits_next;
  logic [icov_pkg::CNT_W-1:0]           obs_base, hits_base;
  logic                                 status_q, status_next;
  logic [icov_pkg::CFG_DATA_W-1:0]      exp_cov;
  logic [icov_pkg::CFG_DATA_W-1:0]      tol;

  logic                                 out_valid;
  logic                                 out_status;
  logic [icov_pkg::CNT_W-1:0]           out_obs;
  logic [icov_pkg::CNT_W-1:0]           out_hits;
  logic [icov_pkg::COV_W-1:0]           out_cov;
  logic                                 out_within;

  logic                                 item_take;
  logic                                 load_out;
  logic                                 div_start;
  logic                                 cfg_bad;
  logic                                 hit;
  logic                                 obs_zero;
  logic [icov_pkg::COV_W-1:0]           cov;
  logic [icov_pkg::CFG_DATA_W-1:0]      band_lo;
  logic [icov_pkg::CFG_DATA_W:0]        band_sum;
  logic [icov_pkg::CFG_DATA_W:0]        band_hi;
  logic                                 band_ok;

  icov_pkg::div_req_t div_req;
  icov_pkg::div_rsp_t div_rsp;

  icov_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign obs_zero = (obs == '0);

  // fsm next state
  always_comb begin
    state_next = state;
    unique case (state)
      icov_pkg::ST_IDLE:   if (item.valid) state_next = icov_pkg::ST_UPDATE;
      icov_pkg::ST_UPDATE: state_next = icov_pkg::ST_MUL;
      icov_pkg::ST_MUL:    state_next = obs_zero ? icov_pkg::ST_WB : icov_pkg::ST_DIV;
      icov_pkg::ST_DIV:    if (!div_rsp.busy) state_next = icov_pkg::ST_WB;
      icov_pkg::ST_WB:     if (!out_valid || result.ready) state_next = icov_pkg::ST_IDLE;
      default:             state_next = icov_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    item_take = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      icov_pkg::ST_IDLE:   item_take = item.valid;
      icov_pkg::ST_UPDATE: ;
      icov_pkg::ST_MUL:    div_start = !obs_zero;
      icov_pkg::ST_DIV:    ;
      icov_pkg::ST_WB:     load_out = !out_valid || result.ready;
      default:             ;
    endcase
  end

  assign item.ready = (state == icov_pkg::ST_IDLE);
  assign div_req    = '{start: div_start,
                        num: icov_pkg::PROD_W'(hits) * icov_pkg::PROD_W'(icov_pkg::PPM_SCALE),
                        den: obs};

  // counter update
  always_comb begin
    cfg_bad = (exp_cov > icov_pkg::PPM_SCALE) || (tol > icov_pkg::PPM_SCALE);
    hit     = (low_q <= real_q) && (real_q <= high_q);
    if (obs >= icov_pkg::OBS_LIMIT) begin
      obs_base  = obs >> 1;
      hits_base = hits >> 1;
    end else begin
      obs_base  = obs;
      hits_base = hits;
    end
    obs_next    = obs;
    hits_next   = hits;
    status_next = icov_pkg::STATUS_OK;
    if (kind_q == icov_pkg::KIND_CLEAR) begin
      obs_next  = '0;
      hits_next = '0;
    end else if (cfg_bad || (low_q > high_q)) begin
      status_next = icov_pkg::STATUS_INVALID;
    end else begin
      obs_next  = obs_base + 1'b1;
      hits_next = hits_base + icov_pkg::CNT_W'(hit);
    end
  end

  // band check
  always_comb begin
    cov      = obs_zero ? '0 : div_rsp.quot;
    band_lo  = (exp_cov > tol) ? (exp_cov - tol) : '0;
    band_sum = {1'b0, exp_cov} + {1'b0, tol};
    band_hi  = (band_sum > {1'b0, icov_pkg::PPM_SCALE}) ? {1'b0, icov_pkg::PPM_SCALE}
                                                          : band_sum;
    band_ok  = !obs_zero && (cov >= band_lo) && ({1'b0, cov} <= band_hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= icov_pkg::ST_IDLE;
      obs       <= '0;
      hits      <= '0;
      exp_cov   <= '0;
      tol       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == icov_pkg::ST_UPDATE) begin
        obs  <= obs_next;
        hits <= hits_next;
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          icov_pkg::REG_EXPECTED:  exp_cov <= cfg.data;
          icov_pkg::REG_TOLERANCE: tol     <= cfg.data;
          default:                 ;
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_take) begin
      kind_q <= item.kind;
      low_q  <= item.interval_low;
      high_q <= item.interval_high;
      real_q <= item.realized;
    end
    if (state == icov_pkg::ST_UPDATE) begin
      status_q <= status_next;
    end
    if (load_out) begin
      out_status <= status_q;
      out_obs    <= obs;
      out_hits   <= hits;
      out_cov    <= cov;
      out_within <= band_ok;
    end
  end

  assign cfg.ready                = 1'b1;
  assign result.valid             = out_valid;
  assign result.status            = out_status;
  assign result.observation_count = out_obs;
  assign result.covered_count     = out_hits;
  assign result.coverage          = out_cov;
  assign result.within_band       = out_within;

endmodule

`default_nettype wire

@@ tb/tb_interval_coverage_tracker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_coverage_tracker_top
// Self-checking bench for the interval coverage tracker. A directed table of
// observations, clears and register writes runs first. Random phases follow,
// each under its own band setting. Every snapshot is compared with a table
// entry or a behavioral tracker, with random idling on the item and result channels.
// ----------------------------------------------------------------------------

module tb_interval_coverage_tracker_top;
  import icov_pkg::*;

  localparam int          HALF_PERIOD     = 10;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          STUCK_LIMIT     = 3000;
  localparam int          DRAIN_CYCLES    = 30;
  localparam logic [63:0] MIN64           = {1'b1, 63'd0};
  localparam logic [63:0] MAX64           = {1'b0, {63{1'b1}}};

  typedef struct packed {
    logic             kind;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] val;
  } item_t;

  typedef struct packed {
    logic             status;
    logic [CNT_W-1:0] obs_count;
    logic [CNT_W-1:0] hit_count;
    logic [COV_W-1:0] coverage;
    logic             in_band;
  } snapshot_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_op_t;

  typedef struct {
    row_op_t               op;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    item_t                 it;
    bit                    typed;
    snapshot_t             want;
  } dir_row_t;

  logic clk;
  logic rst;

  icov_in_if  in_ch ();
  icov_out_if out_ch ();
  icov_cfg_if cfg_ch ();

  interval_coverage_tracker_top uut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (out_ch),
    .cfg    (cfg_ch)
  );

  // tracker state as the block should hold it
  logic [CNT_W-1:0]      obs_total;
  logic [CNT_W-1:0]      hit_total;
  logic [CFG_DATA_W-1:0] band_target;
  logic [CFG_DATA_W-1:0] band_margin;

  snapshot_t   expected_snapshots[$];
  dir_row_t    directed_rows[$];
  int unsigned errors;
  int unsigned n_results;
  int unsigned n_counted;
  int unsigned n_rejected;
  int unsigned n_clears;
  int unsigned n_writes;
  int unsigned peak_obs;
  int unsigned stall_pct;
  int unsigned stuck_cycles;
  bit          quiet;
  bit          hold_off_req;

  initial begin
    clk = 1'b0;
  end

  always #HALF_PERIOD clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < 50) begin
      $display("mismatch on result %0d: %s got %0h expected %0h", n_results, what, got,
               want);
    end
    errors++;
  endtask

  task automatic tracker_step(input item_t it, output snapshot_t snap);
    logic [63:0] ratio;
    logic [20:0] band_lo;
    logic [20:0] band_hi;
    snap = '0;
    snap.status = STATUS_OK;
    if (it.kind == KIND_CLEAR) begin
      obs_total = '0;
      hit_total = '0;
      n_clears++;
    end else if (band_target > PPM_SCALE || band_margin > PPM_SCALE ||
                 $signed(it.lo) > $signed(it.hi)) begin
      snap.status = STATUS_INVALID;
      n_rejected++;
    end else begin
      // both counts halve together so the ratio survives saturation
      if (obs_total >= OBS_LIMIT) begin
        obs_total = obs_total >> 1;
        hit_total = hit_total >> 1;
      end
      obs_total = obs_total + 1'b1;
      if ($signed(it.lo) <= $signed(it.val) && $signed(it.val) <= $signed(it.hi)) begin
        hit_total = hit_total + 1'b1;
      end
      n_counted++;
    end
    if (obs_total != '0) begin
      ratio   = (64'(hit_total) * 64'(PPM_SCALE)) / 64'(obs_total);
      band_lo = (band_target > band_margin) ? 21'(band_target - band_margin) : '0;
      band_hi = 21'(band_target) + 21'(band_margin);
      if (band_hi > 21'(PPM_SCALE)) begin
        band_hi = 21'(PPM_SCALE);
      end
      snap.obs_count = obs_total;
      snap.hit_count = hit_total;
      snap.coverage  = ratio[COV_W-1:0];
      snap.in_band   = (ratio >= 64'(band_lo)) && (ratio <= 64'(band_hi));
      if (int'(obs_total) > peak_obs) begin
        peak_obs = int'(obs_total);
      end
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] corner64();
    case ($urandom_range(0, 5))
      0: return MIN64;
      1: return MAX64;
      2: return '0;
      3: return '1;
      4: return 64'd1;
      default: return rand64();
    endcase
  endfunction

  function automatic item_t make_random_item(input int unsigned hit_pct);
    item_t       it;
    int unsigned pick;
    int unsigned below;
    int unsigned above;
    int          near;
    logic [63:0] mid;
    pick    = $urandom_range(0, 99);
    it.kind = KIND_OBSERVE;
    it.lo   = rand64();
    it.hi   = rand64();
    it.val  = rand64();
    if (pick < 3) begin
      it.kind = KIND_CLEAR;
    end else if (pick < 13) begin
      // noise: unrelated bounds, half of them reversed
    end else if (pick < 20) begin
      it.lo  = corner64();
      it.hi  = corner64();
      it.val = corner64();
    end else begin
      mid     = rand64();
      mid[62] = mid[63];
      if ($urandom_range(0, 2) == 0) begin
        near = int'($urandom_range(0, 2000)) - 1000;
        mid  = 64'(longint'(near));
      end
      below = $urandom_range(0, 1 << $urandom_range(0, 20));
      above = $urandom_range(0, 1 << $urandom_range(0, 20));
      it.lo = mid - 64'(below);
      it.hi = mid + 64'(above);
      if ($urandom_range(0, 99) < hit_pct) begin
        it.val = it.lo + 64'($urandom_range(0, below + above));
      end else if ($urandom_range(0, 1) == 0) begin
        it.val = it.lo - 64'($urandom_range(1, 1000));
      end else begin
        it.val = it.hi + 64'($urandom_range(1, 1000));
      end
    end
    return it;
  endfunction

  function automatic void add_item(input logic kind, input logic [63:0] lo, hi, val);
    dir_row_t row;
    row.op       = ROW_ITEM;
    row.reg_idx  = '0;
    row.reg_data = '0;
    row.it       = '{kind: kind, lo: lo, hi: hi, val: val};
    row.typed    = 1'b0;
    row.want     = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_checked(input logic kind, input logic [63:0] lo, hi, val,
                                      input logic st, input logic [CNT_W-1:0] oc, cc,
                                      input logic [COV_W-1:0] cov, input logic wb);
    add_item(kind, lo, hi, val);
    directed_rows[$].typed = 1'b1;
    directed_rows[$].want  = '{status: st, obs_count: oc, hit_count: cc, coverage: cov,
                               in_band: wb};
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    dir_row_t row;
    row.op       = ROW_WRITE;
    row.reg_idx  = idx;
    row.reg_data = data;
    row.it       = '0;
    row.typed    = 1'b0;
    row.want     = '0;
    directed_rows.push_back(row);
  endfunction

  task automatic send_item(input item_t it, input bit typed, input snapshot_t want);
    snapshot_t pred;
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= it.kind;
    in_ch.interval_low  <= it.lo;
    in_ch.interval_high <= it.hi;
    in_ch.realized      <= it.val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker_step(it, pred);
    expected_snapshots.push_back(typed ? want : pred);
  endtask

  // stop offering items and wait for every outstanding snapshot
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_snapshots.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit more);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_EXPECTED) begin
      band_target = data;
    end else begin
      band_margin = data;
    end
    n_writes++;
    if (!more) begin
      cfg_ch.valid <= 1'b0;
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] target, margin,
                           input int unsigned n_items, input bit with_hold);
    int unsigned hit_pct;
    int unsigned gap_pct;
    write_reg(REG_EXPECTED, target, 1'b1);
    write_reg(REG_TOLERANCE, margin, 1'b0);
    hit_pct   = $urandom_range(0, 100);
    gap_pct   = (quiet || with_hold || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
    stall_pct = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
    for (int k = 0; k < n_items; k++) begin
      if (with_hold && k == 20) begin
        hold_off_req = 1'b1;
      end
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      send_item(make_random_item(hit_pct), 1'b0, '0);
    end
  endtask

  // result side: random stall bursts plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    snapshot_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (expected_snapshots.size() == 0) begin
        report_mismatch("snapshot with none pending", 64'(out_ch.observation_count), '0);
      end else begin
        want = expected_snapshots.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", 64'(out_ch.status), 64'(want.status));
        if (out_ch.observation_count !== want.obs_count)
          report_mismatch("observation_count", 64'(out_ch.observation_count),
                          64'(want.obs_count));
        if (out_ch.covered_count !== want.hit_count)
          report_mismatch("covered_count", 64'(out_ch.covered_count), 64'(want.hit_count));
        if (out_ch.coverage !== want.coverage)
          report_mismatch("coverage", 64'(out_ch.coverage), 64'(want.coverage));
        if (out_ch.within_band !== want.in_band)
          report_mismatch("within_band", 64'(out_ch.within_band), 64'(want.in_band));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("no transaction for %0d cycles, %0d snapshots pending", stuck_cycles,
               expected_snapshots.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst                 <= 1'b1;
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= KIND_OBSERVE;
    in_ch.interval_low  <= '0;
    in_ch.interval_high <= '0;
    in_ch.realized      <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_EXPECTED;
    cfg_ch.data         <= '0;
    obs_total    = '0;
    hit_total    = '0;
    band_target  = '0;
    band_margin  = '0;
    errors       = 0;
    n_results    = 0;
    n_counted    = 0;
    n_rejected   = 0;
    n_clears     = 0;
    n_writes     = 0;
    peak_obs     = 0;
    stuck_cycles = 0;
    stall_pct    = 8;
    quiet        = 1'b0;
    hold_off_req = 1'b0;

    // registers at reset: band is exactly zero
    add_checked(KIND_CLEAR, '0, '0, '0, STATUS_OK, 0, 0, 0, 1'b0);
    add_checked(KIND_OBSERVE, 64'd1, '0, '0, STATUS_INVALID, 0, 0, 0, 1'b0);
    add_checked(KIND_OBSERVE, MIN64, MIN64, MIN64, STATUS_OK, 1, 1, 20'd1000000, 1'b0);
    add_checked(KIND_OBSERVE, MIN64, MAX64, MAX64, STATUS_OK, 2, 2, 20'd1000000, 1'b0);
    add_checked(KIND_OBSERVE, MAX64, MAX64, MIN64, STATUS_OK, 3, 2, 20'd666666, 1'b0);
    add_item(KIND_OBSERVE, '1, '0, '1);
    add_checked(KIND_OBSERVE, '0, '1, '0, STATUS_INVALID, 4, 3, 20'd750000, 1'b0);
    add_item(KIND_OBSERVE, MIN64, MIN64, MAX64);
    add_item(KIND_OBSERVE, MAX64, MIN64, '0);
    add_item(KIND_OBSERVE, '0, '0, 64'd1);
    add_item(KIND_OBSERVE, -64'sd5, 64'd5, 64'd5);
    add_write(REG_EXPECTED, 20'd1000000);
    add_item(KIND_OBSERVE, MIN64, MAX64, '0);
    add_checked(KIND_CLEAR, '1, '1, '1, STATUS_OK, 0, 0, 0, 1'b0);
    add_checked(KIND_OBSERVE, 64'd5, 64'd10, 64'd11, STATUS_OK, 1, 0, 0, 1'b0);
    add_checked(KIND_OBSERVE, 64'd5, 64'd10, 64'd5, STATUS_OK, 2, 1, 20'd500000, 1'b0);
    add_write(REG_TOLERANCE, 20'd1000000);
    add_checked(KIND_OBSERVE, 64'd5, 64'd10, 64'd10, STATUS_OK, 3, 2, 20'd666666, 1'b1);
    // target above full scale rejects every observation, clears still pass
    add_write(REG_EXPECTED, 20'hFFFFF);
    add_item(KIND_OBSERVE, '0, '0, '0);
    add_checked(KIND_CLEAR, '0, '0, '0, STATUS_OK, 0, 0, 0, 1'b0);
    add_checked(KIND_OBSERVE, '0, '0, '0, STATUS_INVALID, 0, 0, 0, 1'b0);
    add_write(REG_EXPECTED, 20'd0);
    add_write(REG_TOLERANCE, 20'hFFFFF);
    add_checked(KIND_OBSERVE, 64'd1, 64'd1, 64'd1, STATUS_INVALID, 0, 0, 0, 1'b0);
    add_write(REG_TOLERANCE, 20'd0);
    add_item(KIND_OBSERVE, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555,
             64'h5555_5555_5555_5555);
    add_item(KIND_OBSERVE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
             64'h2AAA_AAAA_AAAA_AAAA);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].op == ROW_WRITE) begin
        write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_data,
                  r + 1 < directed_rows.size() && directed_rows[r + 1].op == ROW_WRITE);
      end else begin
        send_item(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    run_phase(20'd0, 20'd0, 195, 1'b0);
    run_phase(20'd1000000, 20'd0, 195, 1'b0);
    run_phase(20'd0, 20'd1000000, 195, 1'b1);
    run_phase(20'd1000000, 20'd1000000, 195, 1'b0);
    run_phase(20'hFFFFF, 20'd1000000, 60, 1'b0);
    run_phase(20'd250000, 20'hFFFFF, 60, 1'b0);
    run_phase(20'd500000, 20'd100000, 195, 1'b0);
    repeat (2) begin
      run_phase(20'($urandom_range(0, 1000000)), 20'($urandom_range(0, 200000)), 195, 1'b0);
    end
    // closing phase at full rate on both sides
    quiet = 1'b1;
    run_phase(20'($urandom_range(0, 1000000)), 20'($urandom_range(0, 200000)), 195, 1'b0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d snapshots checked: %0d observations counted, %0d rejected, %0d clears",
             n_results, n_counted, n_rejected, n_clears);
    $display("%0d register writes, peak observation count %0d, %0d mismatches",
             n_writes, peak_obs, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/icov_pkg.sv
design/icov_if.sv
design/icov_div.sv
design/interval_coverage_tracker_top.sv
tb/tb_interval_coverage_tracker_top.sv
